// ----- hdl/mbrq_pkg.sv -----
// Shared types and codes for the motion block ring queue.
// No dependencies; the interfaces and the top level import it.
package mbrq_pkg;

  localparam int KIND_W = 3;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 5;
  localparam int STAT_W = 2;
  localparam int AVAIL_W = 6;
  localparam int MASK_W = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] K_FLUSH   = 3'd0;
  localparam logic [KIND_W-1:0] K_ACQUIRE = 3'd1;
  localparam logic [KIND_W-1:0] K_COMMIT  = 3'd2;
  localparam logic [KIND_W-1:0] K_GET_RUN = 3'd3;
  localparam logic [KIND_W-1:0] K_FREE    = 3'd4;
  localparam logic [KIND_W-1:0] K_PLANNED = 3'd5;

  // Result status
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_RUN  = 2'd2;

  // Slot states
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_PLANNING = 2'd1;
  localparam logic [1:0] ST_QUEUED   = 2'd2;
  localparam logic [1:0] ST_RUNNING  = 2'd3;

  localparam logic [TIME_W-1:0] MIN_PLANNED_RST = 32'd40000;

  typedef struct packed {
    logic [1:0]        st;
    logic [TIME_W-1:0] tm;
  } slot_entry_t;

endpackage

// ----- hdl/mbrq_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on mbrq_pkg for field widths.
interface mbrq_in_if;
  import mbrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              is_motion;
  logic [TIME_W-1:0] move_time_us;
  logic [TIME_W-1:0] runtime_left_us;
  logic [IDX_W-1:0]  slot_index;
  modport source (output valid, kind, is_motion, move_time_us, runtime_left_us, slot_index,
                  input ready);
  modport sink (input valid, kind, is_motion, move_time_us, runtime_left_us, slot_index,
                output ready);
endinterface

interface mbrq_out_if;
  import mbrq_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [IDX_W-1:0]   result_slot;
  logic               queue_empty;
  logic [AVAIL_W-1:0] slots_available;
  logic [TIME_W-1:0]  time_in_planner_us;
  logic               replan_pending;
  logic [MASK_W-1:0]  locked_mask;
  modport source (output valid, status, result_slot, queue_empty, slots_available,
                  time_in_planner_us, replan_pending, locked_mask, input ready);
  modport sink (input valid, status, result_slot, queue_empty, slots_available,
                time_in_planner_us, replan_pending, locked_mask, output ready);
endinterface

interface mbrq_cfg_if;
  import mbrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hdl/motion_block_ring_queue.sv -----
// Motion block ring queue: flush and unused kinds pass from idle to finish; acquire,
// commit, planned and free run pass through execute; get run with a run at the head adds
// a walk over the queued slots (at most POOL_SLOTS-1), one slot per cycle over the memory port.
// A further item is taken once the previous one has reached the output register.
// Synchronous active-low reset: all slots empty and unlocked, pointers zero, free count
// POOL_SLOTS, minimum planned time 40000 us. Slot times are undefined until written.
module motion_block_ring_queue #(
  parameter int POOL_SLOTS = 32
) (
  input logic clk,
  input logic rst_n,
  mbrq_in_if.sink    in_ch,
  mbrq_out_if.source out_ch,
  mbrq_cfg_if.sink   cfg_ch
);
  import mbrq_pkg::*;

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int MW = (POOL_SLOTS > MASK_W) ? POOL_SLOTS : MASK_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SLOTS - 1);
  localparam logic [AW+IDX_W-1:0] POOL_WIDE = (AW + IDX_W)'(POOL_SLOTS);
  localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } seq_t;

  // Slot memory: state and time, one read and one write port, registered read
  slot_entry_t mem [POOL_SLOTS];
  slot_entry_t rd_data_r;
  logic        rd_valid_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  slot_entry_t   mem_wd;

  // Per-slot valid and lock bits in flip-flops
  logic [POOL_SLOTS-1:0] valid_r;
  logic [POOL_SLOTS-1:0] locked_r;

  seq_t          state_r;
  logic [AW-1:0] wptr_r, qptr_r, rptr_r;
  logic [CW-1:0] free_r;
  logic          replan_r;
  logic [TIME_W-1:0] total_r;
  logic [TIME_W-1:0] min_r;

  // Held request
  logic [KIND_W-1:0] kind_r;
  logic              motion_r;
  logic [TIME_W-1:0] move_r;
  logic [TIME_W-1:0] runtime_r;
  logic [IDX_W-1:0]  idx_r;

  // Walk state
  logic [AW-1:0]     walk_p_r;
  logic [TIME_W-1:0] walk_sum_r;

  // Result beat in preparation
  logic [STAT_W-1:0] res_status_r;
  logic [IDX_W-1:0]  res_slot_r;
  logic              res_empty_r;

  logic out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [IDX_W-1:0]   out_slot_r;
  logic               out_empty_r;
  logic [AVAIL_W-1:0] out_avail_r;
  logic [TIME_W-1:0]  out_time_r;
  logic               out_replan_r;
  logic [MASK_W-1:0]  out_mask_r;

  logic in_fire;
  logic [AW-1:0] in_idx_addr, idx_addr;
  logic          idx_ok;
  logic [1:0]    cur_st;
  logic [AW-1:0] rptr_next;
  logic [TIME_W:0] sat_sum;
  logic [TIME_W-1:0] walk_add;
  logic [MW-1:0]   lock_wide;
  logic [CW+AVAIL_W-1:0] free_wide;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot5(input logic [AW-1:0] a);
    logic [AW+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, a};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_to_addr(input logic [IDX_W-1:0] i);
    logic [AW+IDX_W-1:0] w;
    w = {{AW{1'b0}}, i};
    return w[AW-1:0];
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign in_idx_addr = idx_to_addr(in_ch.slot_index);
  assign idx_addr    = idx_to_addr(idx_r);
  assign idx_ok      = ({{AW{1'b0}}, idx_r} < POOL_WIDE);
  assign cur_st      = rd_valid_r ? rd_data_r.st : ST_EMPTY;
  assign rptr_next   = next_slot(rptr_r);

  // Saturating accumulate of the slot time under the walk
  assign sat_sum  = {1'b0, walk_sum_r} + {1'b0, rd_data_r.tm};
  assign walk_add = sat_sum[TIME_W] ? '1 : sat_sum[TIME_W-1:0];

  assign lock_wide = MW'(locked_r);
  assign free_wide = {{AVAIL_W{1'b0}}, free_r};

  // Read address: current pointer or requested index on accept, then the walk slot ahead of the evaluated one
  always_comb begin
    rd_addr = wptr_r;
    unique case (state_r)
      S_IDLE: begin
        unique case (in_ch.kind)
          K_COMMIT:         rd_addr = qptr_r;
          K_GET_RUN,
          K_FREE:           rd_addr = rptr_r;
          K_PLANNED:        rd_addr = in_idx_addr;
          default:          rd_addr = wptr_r;
        endcase
      end
      S_EXEC:  rd_addr = rptr_next;
      S_WALK:  rd_addr = next_slot(walk_p_r);
      default: rd_addr = wptr_r;
    endcase
  end

  // Memory write side: only the execute step modifies an entry
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = wptr_r;
    mem_wd.st = ST_EMPTY;
    mem_wd.tm = '0;
    if (state_r == S_EXEC) begin
      unique case (kind_r)
        K_ACQUIRE: begin
          mem_we    = (cur_st == ST_EMPTY);
          mem_wa    = wptr_r;
          mem_wd.st = ST_PLANNING;
          mem_wd.tm = '0;
        end
        K_COMMIT: begin
          mem_we    = (cur_st == ST_PLANNING);
          mem_wa    = qptr_r;
          mem_wd.st = motion_r ? ST_PLANNING : ST_QUEUED;
          mem_wd.tm = move_r;
        end
        K_GET_RUN: begin
          mem_we    = (cur_st == ST_QUEUED);
          mem_wa    = rptr_r;
          mem_wd.st = ST_RUNNING;
          mem_wd.tm = rd_data_r.tm;
        end
        K_PLANNED: begin
          mem_we    = idx_ok && (cur_st == ST_PLANNING);
          mem_wa    = idx_addr;
          mem_wd.st = ST_QUEUED;
          mem_wd.tm = move_r;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      // A same-entry write and read share a cycle only where the read goes unused; take the bit as it stands
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_PLANNED_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      min_r <= cfg_ch.data;
    end
  end

  // Sequencer and ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      locked_r <= '0;
      wptr_r   <= '0;
      qptr_r   <= '0;
      rptr_r   <= '0;
      free_r   <= FULL_COUNT;
      replan_r <= 1'b0;
      total_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r       <= in_ch.kind;
            motion_r     <= in_ch.is_motion;
            move_r       <= in_ch.move_time_us;
            runtime_r    <= in_ch.runtime_left_us;
            idx_r        <= in_ch.slot_index;
            res_status_r <= STAT_OK;
            res_slot_r   <= '0;
            res_empty_r  <= 1'b0;
            unique case (in_ch.kind)
              K_FLUSH: begin
                // Drop every slot and pointer; the threshold register stays
                valid_r  <= '0;
                locked_r <= '0;
                wptr_r   <= '0;
                qptr_r   <= '0;
                rptr_r   <= '0;
                free_r   <= FULL_COUNT;
                replan_r <= 1'b0;
                total_r  <= '0;
                state_r  <= S_FIN;
              end
              K_ACQUIRE, K_COMMIT, K_GET_RUN, K_FREE, K_PLANNED: state_r <= S_EXEC;
              default: state_r <= S_FIN;
            endcase
          end
        end

        S_EXEC: begin
          state_r <= S_FIN;
          unique case (kind_r)
            K_ACQUIRE: begin
              res_slot_r <= slot5(wptr_r);
              if (cur_st == ST_EMPTY) begin
                valid_r[wptr_r]  <= 1'b1;
                locked_r[wptr_r] <= 1'b0;
                wptr_r           <= next_slot(wptr_r);
                free_r           <= free_r - CW'(1);
              end else begin
                res_status_r <= STAT_REFUSED;
              end
            end
            K_COMMIT: begin
              res_slot_r <= slot5(qptr_r);
              if (cur_st == ST_PLANNING) begin
                qptr_r <= next_slot(qptr_r);
                if (motion_r) begin
                  replan_r <= 1'b1;
                end
              end else begin
                res_status_r <= STAT_REFUSED;
              end
            end
            K_GET_RUN: begin
              res_slot_r <= slot5(rptr_r);
              if (cur_st == ST_QUEUED || cur_st == ST_RUNNING) begin
                // Start the lookahead walk on the slot after the head
                walk_sum_r <= runtime_r;
                walk_p_r   <= rptr_next;
                state_r    <= S_WALK;
              end else begin
                total_r      <= '0;
                res_status_r <= STAT_NO_RUN;
              end
            end
            K_FREE: begin
              res_slot_r <= slot5(rptr_r);
              if (cur_st == ST_QUEUED || cur_st == ST_RUNNING) begin
                valid_r[rptr_r]  <= 1'b0;
                locked_r[rptr_r] <= 1'b0;
                rptr_r           <= rptr_next;
                free_r           <= free_r + CW'(1);
                res_empty_r      <= (wptr_r == rptr_next);
              end else begin
                res_status_r <= STAT_NO_RUN;
              end
            end
            K_PLANNED: begin
              res_slot_r <= idx_r;
              if (idx_ok && cur_st == ST_PLANNING) begin
                replan_r <= 1'b0;
              end else begin
                res_status_r <= STAT_REFUSED;
              end
            end
            default: res_status_r <= STAT_OK;
          endcase
        end

        S_WALK: begin
          // rd_data_r holds the slot at walk_p_r; the next slot is already being read
          if (walk_p_r == rptr_r || walk_p_r == qptr_r || cur_st != ST_QUEUED) begin
            total_r <= walk_sum_r;
            state_r <= S_FIN;
          end else begin
            if (walk_sum_r < min_r) begin
              locked_r[walk_p_r] <= 1'b1;
            end
            walk_sum_r <= walk_add;
            walk_p_r   <= next_slot(walk_p_r);
          end
        end

        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: load the finished beat once the previous one has gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_empty_r  <= res_empty_r;
      out_avail_r  <= free_wide[AVAIL_W-1:0];
      out_time_r   <= total_r;
      out_replan_r <= replan_r;
      out_mask_r   <= lock_wide[MASK_W-1:0];
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.result_slot        = out_slot_r;
  assign out_ch.queue_empty        = out_empty_r;
  assign out_ch.slots_available    = out_avail_r;
  assign out_ch.time_in_planner_us = out_time_r;
  assign out_ch.replan_pending     = out_replan_r;
  assign out_ch.locked_mask        = out_mask_r;

endmodule
